### rtl/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
package lpfp_pkg;

    localparam int unsigned HDR_BYTES    = 6;
    localparam int unsigned HDR_CNT_W    = 3;
    localparam int unsigned HDR_KEEP_W   = 40;
    localparam int unsigned ID_W         = 16;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned HDR_LEN_W    = 32;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned IN_TUSER_W   = 1;
    localparam int unsigned OUT_TDATA_W  = 24;
    localparam int unsigned OUT_TUSER_W  = 3;
    localparam logic [ID_W-1:0] HEARTBEAT_ID = 16'd1000;
    localparam logic [HDR_LEN_W-1:0] MAX_LEN_RST = 32'd65536;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = 3'(HDR_BYTES - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_BODY     = 2'd0,
        KIND_OVERSIZE = 2'd1,
        KIND_EMPTY    = 2'd2
    } t_kind;

    typedef enum logic [IN_TUSER_W-1:0] {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

endpackage

### rtl/length_prefixed_frame_parser_core.sv
// Length-prefixed message deframer: header collection, body pass-through, error halt.
//
//  channel  | direction | tdata (low bit up)               | tuser (low bit up)      | tlast
//  s_axis   | in        | data_byte[7:0]                   | op                      | -
//  m_axis   | out       | message_id[15:0], body_byte[7:0] | kind[1:0], heartbeat    | last
//  cfg      | in        | max_message_length[31:0] on i_cfg_wr_en                     | -
//
// One request a cycle while s_axis_tready is high; a decoded result loads the output register.
// The output register is the only stage; s_axis_tready drops only while it holds
// a result that m_axis has not taken. Reset clears the parser and loads the
// length limit with 65536. A restart request clears the parser, never the limit.
module length_prefixed_frame_parser_core #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lpfp_pkg::HDR_LEN_W-1:0]    i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lpfp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // data_byte[7:0]
    input  logic [lpfp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,   // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lpfp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // message_id[15:0], body_byte[23:16]
    output logic [lpfp_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,   // kind[1:0], heartbeat_reply[2]
    output logic                              m_axis_tlast    // last_of_message
);
    import lpfp_pkg::*;

    logic [HDR_LEN_W-1:0]   r_max_len;
    logic [HDR_CNT_W-1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [HDR_KEEP_W-1:0]  r_hdr_shift, n_hdr_shift;
    logic                   r_in_body, n_in_body;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [ID_W-1:0]        r_cur_id, n_cur_id;
    logic                   r_halted, n_halted;

    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    logic [ID_W-1:0]        r_out_id, n_out_id;
    logic [BYTE_W-1:0]      r_out_byte, n_out_byte;
    logic                   r_out_last, n_out_last;
    logic                   r_out_hb, n_out_hb;

    logic                   accept;
    logic                   emit;
    logic [BYTE_W-1:0]      in_byte;
    logic [ID_W-1:0]        hdr_id;
    logic [HDR_LEN_W-1:0]   hdr_len;
    logic [HDR_LEN_W:0]     hdr_len_ext;
    logic                   too_wide;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_byte       = s_axis_tdata;

    assign hdr_id      = r_hdr_shift[HDR_KEEP_W-1 -: ID_W];
    assign hdr_len     = {r_hdr_shift[HDR_LEN_W-BYTE_W-1:0], in_byte};
    assign hdr_len_ext = {1'b0, hdr_len};
    // a length that overflows the body counter is oversize whatever the limit
    assign too_wide    = (hdr_len_ext >> LENGTH_BITS) != '0;

    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr_shift = r_hdr_shift;
        n_in_body   = r_in_body;
        n_left      = r_left;
        n_cur_id    = r_cur_id;
        n_halted    = r_halted;
        emit        = 1'b0;
        n_out_kind  = KIND_BODY;
        n_out_id    = r_cur_id;
        n_out_byte  = '0;
        n_out_last  = 1'b0;

        if (accept) begin
            if (t_op'(s_axis_tuser) == OP_RESTART) begin
                n_hdr_cnt   = '0;
                n_hdr_shift = '0;
                n_in_body   = 1'b0;
                n_left      = '0;
                n_cur_id    = '0;
                n_halted    = 1'b0;
            end else if (!r_halted) begin
                if (r_in_body) begin
                    emit       = 1'b1;
                    n_out_byte = in_byte;
                    n_out_last = (r_left == LENGTH_BITS'(1));
                    n_left     = r_left - LENGTH_BITS'(1);
                    if (n_out_last) begin
                        n_in_body = 1'b0;
                    end
                end else if (r_hdr_cnt == HDR_LAST_IDX) begin
                    n_hdr_cnt   = '0;
                    n_hdr_shift = '0;
                    n_cur_id    = hdr_id;
                    n_out_id    = hdr_id;
                    if (hdr_len > r_max_len || too_wide) begin
                        emit       = 1'b1;
                        n_halted   = 1'b1;
                        n_out_kind = KIND_OVERSIZE;
                    end else if (hdr_len == '0) begin
                        emit       = 1'b1;
                        n_halted   = 1'b1;
                        n_out_kind = KIND_EMPTY;
                    end else begin
                        n_left    = hdr_len[LENGTH_BITS-1:0];
                        n_in_body = 1'b1;
                    end
                end else begin
                    n_hdr_shift = {r_hdr_shift[HDR_KEEP_W-BYTE_W-1:0], in_byte};
                    n_hdr_cnt   = r_hdr_cnt + HDR_CNT_W'(1);
                end
            end
        end

        n_out_hb = (n_out_id == HEARTBEAT_ID);

        // hold the result until taken, load a new one when the request makes one
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RST;
            r_hdr_cnt   <= '0;
            r_hdr_shift <= '0;
            r_in_body   <= 1'b0;
            r_left      <= '0;
            r_cur_id    <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr_shift <= n_hdr_shift;
            r_in_body   <= n_in_body;
            r_left      <= n_left;
            r_cur_id    <= n_cur_id;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= n_out_kind;
            r_out_id   <= n_out_id;
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
            r_out_hb   <= n_out_hb;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_byte, r_out_id};
    assign m_axis_tuser  = {r_out_hb, r_out_kind};
    assign m_axis_tlast  = r_out_last;

endmodule
